/* rtl/ddsv_pkg.sv */
package ddsv_pkg;

   // defaults for the top level parameters
   localparam int DEF_TABLE_ENTRIES   = 1024;
   localparam int DEF_CONTROL_DIVIDER = 64;
   localparam int DEF_SAMPLE_BITS     = 16;

   // fixed field widths
   localparam int FRAC_BITS   = 16;
   localparam int STEP_W      = 25;
   localparam int OFFSET_W    = 26;
   localparam int PEAK_W      = 16;
   localparam int SLOPE_W     = 32;
   localparam int LEN_W       = 13;
   localparam int PROD_W      = SLOPE_W + LEN_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 32;

   // sustain window half width in table steps, envelope length after reset
   localparam int NEAR_STEPS       = 5;
   localparam int ENV_LENGTH_RESET = 5000;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OSC_STEP   = 3'd0,
      CSR_TREM_STEP  = 3'd1,
      CSR_VIB_STEP   = 3'd2,
      CSR_PEAK_LEVEL = 3'd3,
      CSR_ENV_SLOPE  = 3'd4,
      CSR_ENV_LENGTH = 3'd5
   } csr_index_type;

   // what the envelope does on one tick
   typedef enum logic [1:0] {
      ENV_ZERO,
      ENV_PEAK,
      ENV_SHAPE
   } env_case_type;

   // per item control handed from the tick stage to the output stage
   typedef struct packed {
      env_case_type        env_case;
      logic                rising;
      logic [PROD_W-1:0]   product;
      logic [PEAK_W-1:0]   peak;
      logic                sustain;
      logic                finished;
      logic                strobe;
   } tick_info_type;

   // pi in unsigned 4.60 and the taylor series divisors (2k)(2k+1)
   localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
   localparam int TAYLOR_TERMS = 12;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

   // (a * b) >> 60 for operands below 2^62
   function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
      longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
      al  = a & 64'hFFFF_FFFF;
      ah  = a >> 32;
      bl  = b & 64'hFFFF_FFFF;
      bh  = b >> 32;
      ll  = al * bl;
      lh  = al * bh;
      hl  = ah * bl;
      hh  = ah * bh;
      mid = (ll >> 32) + (lh & 64'hFFFF_FFFF) + (hl & 64'hFFFF_FFFF);
      lo  = (ll & 64'hFFFF_FFFF) | (mid << 32);
      hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
      return (hi << 4) | (lo >> 60);
   endfunction

   // one sine table entry, rounded half away from zero, evaluated at elaboration
   function automatic int sine_entry(longint unsigned Index, longint unsigned Entries,
                                     int SampleBits);
      longint unsigned a, x, term, mag, amp;
      longint          s;
      logic            neg;
      amp = (64'd1 << (SampleBits - 1)) - 64'd1;
      a   = 64'd2 * Index;
      neg = 1'b0;
      if (a >= Entries) begin
         a   = a - Entries;
         neg = 1'b1;
      end
      if (64'd2 * a > Entries) begin
         a = Entries - a;
      end
      // angle pi * a / entries in 4.60
      x    = (PI_Q60 / Entries) * a + ((PI_Q60 % Entries) * a) / Entries;
      s    = longint'(x);
      term = x;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = mul_q60(mul_q60(term, x), x) / TAYLOR_DIV[k-1];
         if (k[0]) begin
            s = s - longint'(term);
         end else begin
            s = s + longint'(term);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      mag = (((unsigned'(s)) >> 28) * amp + 64'h8000_0000) >> 32;
      // thirty degrees sits exactly on a half
      if (64'd6 * a == Entries) begin
         mag = (amp + 64'd1) >> 1;
      end
      if (mag > amp) begin
         mag = amp;
      end
      return neg ? -int'(mag) : int'(mag);
   endfunction

endpackage

/* rtl/ddsv_sine_rom.sv */
module ddsv_sine_rom #(
   parameter int ENTRIES     = ddsv_pkg::DEF_TABLE_ENTRIES,
   parameter int SAMPLE_BITS = ddsv_pkg::DEF_SAMPLE_BITS,
   localparam int ADDR_W     = $clog2(ENTRIES)
) (
   input  logic                   clock,
   input  logic                   read_en,
   input  logic [ADDR_W-1:0]      read_addr,
   output logic [SAMPLE_BITS-1:0] read_data
);
   import ddsv_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] rom_word_type;
   typedef rom_word_type rom_image_type [ENTRIES];

   // one full sine period, built at elaboration
   function automatic rom_image_type build_image();
      rom_image_type image;
      for (int i = 0; i < ENTRIES; i++) begin
         image[i] = SAMPLE_BITS'(sine_entry(i, ENTRIES, SAMPLE_BITS));
      end
      return image;
   endfunction

   localparam rom_image_type ROM_IMAGE = build_image();

   logic [SAMPLE_BITS-1:0] read_data_ff;

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= ROM_IMAGE[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* rtl/ddsv_tick.sv */
module ddsv_tick #(
   parameter int TABLE_ENTRIES   = ddsv_pkg::DEF_TABLE_ENTRIES,
   parameter int CONTROL_DIVIDER = ddsv_pkg::DEF_CONTROL_DIVIDER,
   localparam int ADDR_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [ddsv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ddsv_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              advance,
   input  logic                              note_on,
   input  logic                              lfo_advance,
   input  logic signed [ddsv_pkg::OFFSET_W-1:0] freq_offset_step,
   output logic [ADDR_W-1:0]                 osc_addr,
   output logic [ADDR_W-1:0]                 trem_addr,
   output logic [ADDR_W-1:0]                 vib_addr,
   output ddsv_pkg::tick_info_type           info
);
   import ddsv_pkg::*;

   // phases are table index over FRAC_BITS fraction; table size is a power of two
   localparam int PHASE_W = ADDR_W + FRAC_BITS;
   localparam int SUM_W   = (PHASE_W > OFFSET_W) ? PHASE_W : OFFSET_W;
   localparam int RATE_W  = (CONTROL_DIVIDER > 1) ? $clog2(CONTROL_DIVIDER) : 1;
   localparam logic [RATE_W-1:0]  RATE_LAST  = RATE_W'(CONTROL_DIVIDER - 1);
   localparam logic [PHASE_W-1:0] QUARTER3   = PHASE_W'(3 * TABLE_ENTRIES / 4) << FRAC_BITS;
   localparam logic [PHASE_W-1:0] NEAR_WIN   = PHASE_W'(NEAR_STEPS) << FRAC_BITS;
   localparam logic [PHASE_W-1:0] VIB_LOW    = QUARTER3 - NEAR_WIN;
   localparam logic [PHASE_W-1:0] VIB_HIGH   = QUARTER3 + NEAR_WIN;

   // configuration registers
   logic [STEP_W-1:0]  osc_step_ff, trem_step_ff, vib_step_ff;
   logic [PEAK_W-1:0]  peak_level_ff;
   logic [SLOPE_W-1:0] env_slope_ff;
   logic [LEN_W-1:0]   env_length_ff;

   // voice state
   logic [PHASE_W-1:0] osc_phase_ff, osc_phase_in;
   logic [PHASE_W-1:0] trem_phase_ff, trem_phase_in;
   logic [PHASE_W-1:0] vib_phase_ff, vib_phase_in;
   logic [LEN_W-1:0]   env_count_ff, env_count_in;
   logic               sustain_ff, sustain_in;
   logic [RATE_W-1:0]  rate_count_ff, rate_count_in;

   logic [SUM_W-1:0]   osc_sum, trem_sum, vib_sum;
   logic [LEN_W-1:0]   half, mul_operand;
   logic               rising, peak_hit, finished, near_hit;
   env_case_type       env_case;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         osc_step_ff   <= '0;
         trem_step_ff  <= '0;
         vib_step_ff   <= '0;
         peak_level_ff <= '0;
         env_slope_ff  <= '0;
         env_length_ff <= LEN_W'(ENV_LENGTH_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OSC_STEP:   osc_step_ff   <= csr_data[STEP_W-1:0];
            CSR_TREM_STEP:  trem_step_ff  <= csr_data[STEP_W-1:0];
            CSR_VIB_STEP:   vib_step_ff   <= csr_data[STEP_W-1:0];
            CSR_PEAK_LEVEL: peak_level_ff <= csr_data[PEAK_W-1:0];
            CSR_ENV_SLOPE:  env_slope_ff  <= csr_data[SLOPE_W-1:0];
            CSR_ENV_LENGTH: env_length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // phase accumulators, wrapping modulo the table span
   always_comb begin
      osc_sum  = SUM_W'(osc_phase_ff) + SUM_W'(osc_step_ff) + SUM_W'(freq_offset_step);
      trem_sum = SUM_W'(trem_phase_ff) + SUM_W'(trem_step_ff);
      vib_sum  = SUM_W'(vib_phase_ff) + SUM_W'(vib_step_ff);
      osc_phase_in  = osc_sum[PHASE_W-1:0];
      trem_phase_in = lfo_advance ? trem_sum[PHASE_W-1:0] : trem_phase_ff;
      vib_phase_in  = lfo_advance ? vib_sum[PHASE_W-1:0] : vib_phase_ff;
   end

   // envelope decision and the slope multiply
   always_comb begin
      half         = env_length_ff >> 1;
      rising       = env_count_ff < half;
      mul_operand  = rising ? env_count_ff : env_count_ff - half;
      env_case     = ENV_SHAPE;
      env_count_in = env_count_ff + 1'b1;
      peak_hit     = 1'b0;
      finished     = 1'b0;
      priority if (env_count_ff >= env_length_ff) begin
         env_case     = ENV_ZERO;
         env_count_in = '0;
      end else if (env_count_ff == half && note_on) begin
         env_case     = ENV_PEAK;
         env_count_in = env_count_ff;
         peak_hit     = 1'b1;
      end else if (!note_on && env_count_ff == '0) begin
         env_case     = ENV_ZERO;
         env_count_in = env_count_ff;
         finished     = 1'b1;
      end else begin
         env_case     = ENV_SHAPE;
      end
   end

   // sustain clears near the lfo marks, sets at the held peak
   always_comb begin
      near_hit   = (vib_phase_ff > VIB_LOW && vib_phase_ff < VIB_HIGH) ||
                   (trem_phase_ff < NEAR_WIN);
      sustain_in = peak_hit ? 1'b1 : (near_hit ? 1'b0 : sustain_ff);
   end

   // control rate divider
   always_comb begin
      rate_count_in = (rate_count_ff == RATE_LAST) ? '0 : rate_count_ff + 1'b1;
   end

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         osc_phase_ff  <= '0;
         trem_phase_ff <= QUARTER3;
         vib_phase_ff  <= '0;
         env_count_ff  <= '0;
         sustain_ff    <= 1'b0;
         rate_count_ff <= '0;
      end else if (advance) begin
         osc_phase_ff  <= osc_phase_in;
         trem_phase_ff <= trem_phase_in;
         vib_phase_ff  <= vib_phase_in;
         env_count_ff  <= env_count_in;
         sustain_ff    <= sustain_in;
         rate_count_ff <= rate_count_in;
      end
   end

   // table addresses from the phases at the start of the tick
   assign osc_addr  = osc_phase_ff[PHASE_W-1:FRAC_BITS];
   assign trem_addr = trem_phase_ff[PHASE_W-1:FRAC_BITS];
   assign vib_addr  = vib_phase_ff[PHASE_W-1:FRAC_BITS];

   always_comb begin
      info.env_case = env_case;
      info.rising   = rising;
      info.product  = PROD_W'(env_slope_ff) * PROD_W'(mul_operand);
      info.peak     = peak_level_ff;
      info.sustain  = sustain_in;
      info.finished = finished;
      info.strobe   = (rate_count_ff == '0);
   end

endmodule

/* rtl/dds_voice_with_envelope_and_lfos.sv */
// Sample rate voice: sine oscillator, triangular note envelope, tremolo and
// vibrato sine LFOs and a control rate divider.
//
// req channel: one item per audio sample tick. tdata carries note_on,
// lfo_advance and the signed freq_offset_step. rsp channel: one item per
// request with the three sine samples, envelope value and status flags.
// csr channel: register writes by index, always ready; write only while no
// item is in flight.
//
// An item accepted on req passes through the table stage, the registered
// read of the sine tables and the envelope product, and then the output
// register before it is shown on rsp. Throughput: one item per cycle
// while rsp_tready stays high.
//
// A stalled rsp holds its item; req keeps taking items until the table
// stage is also full, then req_tready drops. Reset (synchronous) clears
// both stages, returns phases, envelope, sustain and divider to their
// start values and the registers to their defaults. The sine tables are
// constant, so no clearing pass follows reset.
module dds_voice_with_envelope_and_lfos #(
   parameter int TABLE_ENTRIES   = ddsv_pkg::DEF_TABLE_ENTRIES,
   parameter int CONTROL_DIVIDER = ddsv_pkg::DEF_CONTROL_DIVIDER,
   parameter int SAMPLE_BITS     = ddsv_pkg::DEF_SAMPLE_BITS,
   localparam int RSP_W          = ((3 * SAMPLE_BITS + ddsv_pkg::PEAK_W + 3 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // note_on, lfo_advance, freq_offset_step
   input  logic [ddsv_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // osc_sample, env_value, trem_value, vib_value, sustain_active,
   // note_finished, control_strobe
   output logic [RSP_W-1:0]                 rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ddsv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ddsv_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ddsv_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int DIFF_W = PROD_W - FRAC_BITS;

   logic                    accept, out_load;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tick_info_type           info, s1_info_ff;
   logic [ADDR_W-1:0]       osc_addr, trem_addr, vib_addr;
   logic [SAMPLE_BITS-1:0]  osc_sample, trem_value, vib_value;
   logic [DIFF_W-1:0]       env_delta;
   logic [PEAK_W-1:0]       env_value;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                    note_on, lfo_advance;
   logic signed [OFFSET_W-1:0] freq_offset_step;

   // request fields
   assign note_on          = req_tdata[0];
   assign lfo_advance      = req_tdata[1];
   assign freq_offset_step = signed'(req_tdata[OFFSET_W+1:2]);

   // two stage flow control, each stage loads when the next one frees
   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ddsv_tick #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .CONTROL_DIVIDER (CONTROL_DIVIDER)
   ) u_tick (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .advance          (accept),
      .note_on          (note_on),
      .lfo_advance      (lfo_advance),
      .freq_offset_step (freq_offset_step),
      .osc_addr         (osc_addr),
      .trem_addr        (trem_addr),
      .vib_addr         (vib_addr),
      .info             (info)
   );

   // one table copy per read port
   ddsv_sine_rom #(.ENTRIES(TABLE_ENTRIES), .SAMPLE_BITS(SAMPLE_BITS)) u_osc_rom (
      .clock (clock), .read_en (accept), .read_addr (osc_addr), .read_data (osc_sample)
   );

   ddsv_sine_rom #(.ENTRIES(TABLE_ENTRIES), .SAMPLE_BITS(SAMPLE_BITS)) u_trem_rom (
      .clock (clock), .read_en (accept), .read_addr (trem_addr), .read_data (trem_value)
   );

   ddsv_sine_rom #(.ENTRIES(TABLE_ENTRIES), .SAMPLE_BITS(SAMPLE_BITS)) u_vib_rom (
      .clock (clock), .read_en (accept), .read_addr (vib_addr), .read_data (vib_value)
   );

   // table stage control, alongside the registered table reads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
   end

   // envelope finish: saturate the rise, subtract the fall from the peak
   always_comb begin
      env_delta = s1_info_ff.product[PROD_W-1:FRAC_BITS];
      unique case (s1_info_ff.env_case)
         ENV_ZERO: env_value = '0;
         ENV_PEAK: env_value = s1_info_ff.peak;
         ENV_SHAPE: begin
            if (s1_info_ff.rising) begin
               env_value = (env_delta > DIFF_W'({PEAK_W{1'b1}})) ? '1
                                                                  : env_delta[PEAK_W-1:0];
            end else begin
               env_value = (env_delta >= DIFF_W'(s1_info_ff.peak)) ? '0
                         : s1_info_ff.peak - env_delta[PEAK_W-1:0];
            end
         end
         default: env_value = '0;
      endcase
   end

   // output register
   always_comb begin
      rsp_data_in = RSP_W'({s1_info_ff.strobe, s1_info_ff.finished, s1_info_ff.sustain,
                            vib_value, trem_value, env_value, osc_sample});
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/ddsv_checker.sv */
module ddsv_checker #(
   parameter int SAMPLE_BITS = ddsv_pkg::DEF_SAMPLE_BITS,
   parameter int RSP_W       = 72
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   import ddsv_pkg::*;

   localparam int ENV_LSB = SAMPLE_BITS;
   localparam int FIN_BIT = 3 * SAMPLE_BITS + PEAK_W + 1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // with the output empty the block takes a new item
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // a finished note has no envelope
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[FIN_BIT] |-> rsp_tdata[ENV_LSB +: PEAK_W] == '0)
      else $error("note finished with nonzero envelope");

   // sine samples are symmetric, the most negative code never appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SAMPLE_BITS-1:0] != SAMPLE_MIN)
      else $error("oscillator sample out of range");

endmodule

bind dds_voice_with_envelope_and_lfos ddsv_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .RSP_W       (RSP_W)
) u_ddsv_checker (.*);

/* tb/dds_voice_with_envelope_and_lfos_test.sv */
module dds_voice_with_envelope_and_lfos_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ddsv_pkg::*;

   localparam int TABLE_N       = DEF_TABLE_ENTRIES;
   localparam int DIVIDE_N      = DEF_CONTROL_DIVIDER;
   localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
   localparam int INDEX_W       = $clog2(TABLE_N);
   localparam int PHASE_W       = INDEX_W + FRAC_BITS;
   localparam int RSP_W         = ((3 * SAMPLE_W + PEAK_W + 3 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 172;
   localparam int DIRECTED_ROWS = 22;
   localparam int TYPED_ROWS    = 4;

   localparam longint unsigned PI_FIX   = 64'h3243_F6A8_885A_308D;
   localparam longint unsigned SINE_AMP = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
   localparam logic [PHASE_W-1:0] THREE_QUARTER = PHASE_W'(3 * TABLE_N / 4) << FRAC_BITS;
   localparam logic [PHASE_W-1:0] NEAR_WINDOW   = PHASE_W'(NEAR_STEPS) << FRAC_BITS;

   // one result item, field by field
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] osc;
      logic [PEAK_W-1:0]          env;
      logic signed [SAMPLE_W-1:0] trem;
      logic signed [SAMPLE_W-1:0] vib;
      logic                       sustain;
      logic                       finished;
      logic                       strobe;
   } voice_out_type;

   // one directed tick, with a typed result where it is obvious
   typedef struct {
      bit                  note;
      bit                  adv;
      logic [OFFSET_W-1:0] offset;
      bit                  typed;
      voice_out_type       want;
   } tick_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // voice model state and register copies
   logic signed [SAMPLE_W-1:0] sine_lut [TABLE_N];
   logic [PHASE_W-1:0]         osc_ph, trem_ph, vib_ph;
   logic [LEN_W-1:0]           env_cnt;
   logic                       sustain_on;
   int                         div_cnt;
   logic [STEP_W-1:0]          osc_inc, trem_inc, vib_inc;
   logic [PEAK_W-1:0]          peak_cfg;
   logic [SLOPE_W-1:0]         slope_cfg;
   logic [LEN_W-1:0]           env_len;

   voice_out_type voice_due [$];
   int         err_count     = 0;
   int         rsp_count     = 0;
   int         cycle_count   = 0;
   int         req_idle_pct  = 0;
   int         rsp_stall_pct = 0;
   logic       hold_req      = 1'b0;
   logic       hold_ack      = 1'b0;
   int         hold_left     = 0;

   tick_row_type tick_table [DIRECTED_ROWS] = '{
      // defaults after reset: steps zero, note released, divider at zero
      '{1'b0, 1'b0, 26'h0000000, 1'b1, '{16'sd0, 16'd0, -16'sd32767, 16'sd0, 1'b0, 1'b1, 1'b1}},
      '{1'b0, 1'b1, 26'h1000000, 1'b1, '{16'sd0, 16'd0, -16'sd32767, 16'sd0, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 1'b0, 26'h2000000, 1'b1,
        '{16'sd32767, 16'd0, -16'sd32767, 16'sd0, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 1'b1, 26'h1FFFFFF, 1'b1,
        '{-16'sd32767, 16'd0, -16'sd32767, 16'sd0, 1'b0, 1'b1, 1'b0}},
      // steep envelope of length 8: rise, peak hold, sustain clears, fall, finish
      '{1'b1, 1'b0, 26'h0000000, 1'b0, '0},
      '{1'b1, 1'b0, 26'h3FFFFFF, 1'b0, '0},
      '{1'b1, 1'b0, 26'h1555555, 1'b0, '0},
      '{1'b1, 1'b0, 26'h2AAAAAA, 1'b0, '0},
      '{1'b1, 1'b1, 26'h0000000, 1'b0, '0},
      '{1'b1, 1'b0, 26'h2000000, 1'b0, '0},
      '{1'b1, 1'b1, 26'h1FFFFFF, 1'b0, '0},
      '{1'b0, 1'b0, 26'h3FFFFFF, 1'b0, '0},
      '{1'b0, 1'b1, 26'h0000001, 1'b0, '0},
      '{1'b0, 1'b0, 26'h2AAAAAA, 1'b0, '0},
      '{1'b0, 1'b0, 26'h1555555, 1'b0, '0},
      '{1'b0, 1'b1, 26'h2000000, 1'b0, '0},
      '{1'b0, 1'b0, 26'h0000000, 1'b0, '0},
      '{1'b1, 1'b1, 26'h1FFFFFF, 1'b0, '0},
      '{1'b0, 1'b0, 26'h3FFFFFE, 1'b0, '0},
      '{1'b1, 1'b0, 26'h0000000, 1'b0, '0},
      '{1'b0, 1'b1, 26'h2000001, 1'b0, '0},
      '{1'b1, 1'b1, 26'h3FFFFFF, 1'b0, '0}
   };

   dds_voice_with_envelope_and_lfos u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // sine table from a taylor series in 4.60 fixed point, one quadrant folded
   initial begin : fill_sine
      longint unsigned ang, x, term, mag;
      longint          acc;
      logic [127:0]    prod;
      logic            neg;
      for (int i = 0; i < TABLE_N; i++) begin
         ang = 64'(2 * i);
         neg = 1'b0;
         if (ang >= TABLE_N) begin
            ang = ang - TABLE_N;
            neg = 1'b1;
         end
         if (2 * ang > TABLE_N) begin
            ang = TABLE_N - ang;
         end
         x    = (PI_FIX / TABLE_N) * ang + ((PI_FIX % TABLE_N) * ang) / TABLE_N;
         acc  = longint'(x);
         term = x;
         for (int k = 1; k <= 12; k++) begin
            prod = term * x;
            term = prod[123:60];
            prod = term * x;
            term = prod[123:60] / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         mag = ((unsigned'(acc) >> 28) * SINE_AMP + 64'h8000_0000) >> 32;
         // thirty degrees lands exactly on a half
         if (6 * ang == TABLE_N) begin
            mag = (SINE_AMP + 1) >> 1;
         end
         if (mag > SINE_AMP) begin
            mag = SINE_AMP;
         end
         sine_lut[i] = neg ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
      end
   end

   // one sample tick of the voice; returns the result item it causes
   function automatic voice_out_type advance_voice(bit note, bit adv, logic [OFFSET_W-1:0] off);
      voice_out_type      res;
      logic [PHASE_W-1:0] vib_gap;
      logic [LEN_W-1:0]   half;
      logic [PROD_W-1:0]  drop;
      res      = '0;
      res.osc  = sine_lut[osc_ph[PHASE_W-1 -: INDEX_W]];
      res.trem = sine_lut[trem_ph[PHASE_W-1 -: INDEX_W]];
      res.vib  = sine_lut[vib_ph[PHASE_W-1 -: INDEX_W]];
      // sustain drops near the vibrato trough or the tremolo wrap
      vib_gap = (vib_ph >= THREE_QUARTER) ? vib_ph - THREE_QUARTER : THREE_QUARTER - vib_ph;
      if (vib_gap < NEAR_WINDOW || trem_ph < NEAR_WINDOW) begin
         sustain_on = 1'b0;
      end
      // envelope
      half = env_len >> 1;
      if (env_cnt >= env_len) begin
         env_cnt = '0;
      end else if (env_cnt == half && note) begin
         sustain_on = 1'b1;
         res.env    = peak_cfg;
      end else if (!note && env_cnt == '0) begin
         res.finished = 1'b1;
      end else begin
         if (env_cnt < half) begin
            drop    = (slope_cfg * PROD_W'(env_cnt)) >> FRAC_BITS;
            res.env = (drop > 65535) ? 16'hFFFF : drop[PEAK_W-1:0];
         end else begin
            drop    = (slope_cfg * PROD_W'(env_cnt - half)) >> FRAC_BITS;
            res.env = (drop >= peak_cfg) ? '0 : peak_cfg - drop[PEAK_W-1:0];
         end
         env_cnt = env_cnt + 1'b1;
      end
      // phases wrap at the table span, a negative sum wraps upward
      osc_ph = osc_ph + PHASE_W'(osc_inc) + off;
      if (adv) begin
         trem_ph = trem_ph + PHASE_W'(trem_inc);
         vib_ph  = vib_ph + PHASE_W'(vib_inc);
      end
      res.strobe  = (div_cnt == 0);
      div_cnt     = (div_cnt + 1) % DIVIDE_N;
      res.sustain = sustain_on;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      err_count++;
      if (err_count <= 60) begin
         $display("item %0d: %s got %0d expected %0d", rsp_count, field, got, want);
      end
   endtask

   // compare one result item with the oldest expectation
   task automatic check_voice(logic [RSP_W-1:0] data);
      voice_out_type got, want;
      got.osc      = data[SAMPLE_W-1:0];
      got.env      = data[SAMPLE_W +: PEAK_W];
      got.trem     = data[SAMPLE_W + PEAK_W +: SAMPLE_W];
      got.vib      = data[2 * SAMPLE_W + PEAK_W +: SAMPLE_W];
      got.sustain  = data[3 * SAMPLE_W + PEAK_W];
      got.finished = data[3 * SAMPLE_W + PEAK_W + 1];
      got.strobe   = data[3 * SAMPLE_W + PEAK_W + 2];
      if (voice_due.size() == 0) begin
         report_mismatch("item with nothing pending", 0, 0);
      end else begin
         want = voice_due.pop_front();
         if (got.osc !== want.osc) report_mismatch("osc_sample", got.osc, want.osc);
         if (got.env !== want.env) report_mismatch("env_value", got.env, want.env);
         if (got.trem !== want.trem) report_mismatch("trem_value", got.trem, want.trem);
         if (got.vib !== want.vib) report_mismatch("vib_value", got.vib, want.vib);
         if (got.sustain !== want.sustain) begin
            report_mismatch("sustain_active", got.sustain, want.sustain);
         end
         if (got.finished !== want.finished) begin
            report_mismatch("note_finished", got.finished, want.finished);
         end
         if (got.strobe !== want.strobe) begin
            report_mismatch("control_strobe", got.strobe, want.strobe);
         end
      end
      rsp_count++;
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_voice(rsp_tdata);
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dds_voice_with_envelope_and_lfos_test NOT OK");
         $finish;
      end
   end

   // offer one tick, then predict it once accepted
   task automatic send_tick(bit note, bit adv, logic [OFFSET_W-1:0] off, bit typed,
                            voice_out_type want);
      voice_out_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, off, adv, note};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_voice(note, adv, off);
      voice_due.push_back(typed ? want : predicted);
   endtask

   task automatic write_voice_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_OSC_STEP:   osc_inc   = value[STEP_W-1:0];
         CSR_TREM_STEP:  trem_inc  = value[STEP_W-1:0];
         CSR_VIB_STEP:   vib_inc   = value[STEP_W-1:0];
         CSR_PEAK_LEVEL: peak_cfg  = value[PEAK_W-1:0];
         CSR_ENV_SLOPE:  slope_cfg = value[SLOPE_W-1:0];
         CSR_ENV_LENGTH: env_len   = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_voice(logic [STEP_W-1:0] osc, logic [STEP_W-1:0] trem,
                                logic [STEP_W-1:0] vib, logic [PEAK_W-1:0] pk,
                                logic [SLOPE_W-1:0] sl, logic [LEN_W-1:0] ln);
      write_voice_reg(CSR_OSC_STEP, CSR_DATA_W'(osc));
      write_voice_reg(CSR_TREM_STEP, CSR_DATA_W'(trem));
      write_voice_reg(CSR_VIB_STEP, CSR_DATA_W'(vib));
      write_voice_reg(CSR_PEAK_LEVEL, CSR_DATA_W'(pk));
      write_voice_reg(CSR_ENV_SLOPE, CSR_DATA_W'(sl));
      write_voice_reg(CSR_ENV_LENGTH, CSR_DATA_W'(ln));
      csr_valid <= 1'b0;
   endtask

   // stop offering, let every pending item come back, then settle
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (voice_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      bit                  note_level;
      bit                  note;
      bit                  adv;
      int                  run_left;
      int                  small_off;
      int                  adv_pct;
      logic [OFFSET_W-1:0] off;
      logic [PEAK_W-1:0]   pk;
      logic [LEN_W-1:0]    ln;
      logic [SLOPE_W-1:0]  sl;

      // voice state after reset
      osc_ph     = '0;
      trem_ph    = THREE_QUARTER;
      vib_ph     = '0;
      env_cnt    = '0;
      sustain_on = 1'b0;
      div_cnt    = 0;
      osc_inc    = '0;
      trem_inc   = '0;
      vib_inc    = '0;
      peak_cfg   = '0;
      slope_cfg  = '0;
      env_len    = LEN_W'(ENV_LENGTH_RESET);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed ticks at the reset register values
      for (int r = 0; r < TYPED_ROWS; r++) begin
         send_tick(tick_table[r].note, tick_table[r].adv, tick_table[r].offset,
                   tick_table[r].typed, tick_table[r].want);
      end
      finish_phase();

      // directed ticks with extreme steps and a short steep envelope
      program_voice(25'h1FFFFFF, 25'h1000000, 25'h1800000, 16'hFFFF, 32'hFFFF_FFFF, 13'd8);
      for (int r = TYPED_ROWS; r < DIRECTED_ROWS; r++) begin
         send_tick(tick_table[r].note, tick_table[r].adv, tick_table[r].offset,
                   tick_table[r].typed, tick_table[r].want);
      end
      finish_phase();

      // random phases, each with its own settings and idling
      note_level = 1'b0;
      run_left   = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            program_voice(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                          13'd8191);
         end else if (p == 1) begin
            program_voice('0, '0, '0, '0, '0, 13'd2);
         end else begin
            pk = PEAK_W'($urandom_range(0, 65535));
            ln = LEN_W'($urandom_range(2, 48));
            if ($urandom_range(0, 1) == 1) begin
               sl = SLOPE_W'((longint'(pk) << FRAC_BITS) / (ln >> 1));
            end else begin
               sl = $urandom;
            end
            program_voice(STEP_W'($urandom), STEP_W'($urandom_range(0, 32'h80000)),
                          STEP_W'($urandom_range(0, 32'h80000)), pk, sl, ln);
         end
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct = 58; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct <= 58; end
            default: begin req_idle_pct = 6; rsp_stall_pct <= 6; end
         endcase
         adv_pct = $urandom_range(20, 100);
         // back pressure: the receiver holds off while items keep coming
         if (p == 4) begin
            hold_req <= ~hold_req;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // notes held and released in runs, with some noise
            if (run_left == 0) begin
               note_level = ~note_level;
               run_left   = $urandom_range(1, ((env_len > 60) ? 60 : int'(env_len)) + 4);
            end
            run_left--;
            note = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : note_level;
            adv  = ($urandom_range(0, 99) < adv_pct);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  small_off = int'($urandom_range(0, 4000)) - 2000;
                  off       = OFFSET_W'(small_off);
               end
               6, 7, 8: off = OFFSET_W'($urandom);
               default: off = ($urandom_range(0, 1) == 1) ? 26'h2000000 : 26'h1FFFFFF;
            endcase
            send_tick(note, adv, off, 1'b0, '0);
         end
         finish_phase();
      end

      if (err_count == 0) begin
         $display("dds_voice_with_envelope_and_lfos_test OK");
      end else begin
         $display("dds_voice_with_envelope_and_lfos_test NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ddsv_pkg.sv
rtl/ddsv_sine_rom.sv
rtl/ddsv_tick.sv
rtl/dds_voice_with_envelope_and_lfos.sv
rtl/ddsv_checker.sv
tb/dds_voice_with_envelope_and_lfos_test.sv
